### design/ttg_pkg.sv
// Shared constants, codes and types of the text terminal grid.
`default_nettype none
package ttg_pkg;

  // Grid geometry and escape length limit.
  localparam int MAX_COLUMNS  = 64;
  localparam int MAX_ROWS     = 32;
  localparam int ESCAPE_LIMIT = 20;

  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int GRID_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int CNT_W      = $clog2(ESCAPE_LIMIT);

  // Fixed field widths of the ports.
  localparam int CELL_COL_W = 6;
  localparam int CELL_ROW_W = 5;
  localparam int PIX_W      = 11;
  localparam int CODE_W     = 8;
  localparam int ORIGIN_W   = 10;
  localparam int COLS_REG_W = 7;
  localparam int ROWS_REG_W = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int ACC_W      = 8;

  localparam int RES_COL_W = (COL_W > CELL_COL_W) ? COL_W : CELL_COL_W;
  localparam int RES_ROW_W = (ROW_W > CELL_ROW_W) ? ROW_W : CELL_ROW_W;

  // Pixel size of one character cell.
  localparam int CELL_W = 6;
  localparam int CELL_H = 8;

  // Character codes.
  localparam logic [CODE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CODE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CODE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CODE_W-1:0] CH_H     = 8'h48;
  localparam logic [CODE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [ACC_W-1:0]  ACC_MAX  = 8'hFF;

  // Command and result kinds.
  localparam logic CMD_FEED  = 1'b0;
  localparam logic CMD_READ  = 1'b1;
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS  = 3'd0,
    REG_ROWS     = 3'd1,
    REG_ORIGIN_X = 3'd2,
    REG_ORIGIN_Y = 3'd3,
    REG_VISIBLE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAW,
    ST_SCROLL,
    ST_WIPE,
    ST_POST
  } ctrl_state_t;

  // Decoded byte from the escape parser.
  typedef struct packed {
    logic             draw;
    logic             set_cur;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } parse_t;

  // Effective view settings from the configuration registers.
  typedef struct packed {
    logic [COL_W-1:0]    last_col;
    logic [ROW_W-1:0]    last_row;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic                visible;
  } view_t;

  // Grid memory request.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CODE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

### design/ttg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ttg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/ttg_parser.sv
// Byte classifier and escape sequence parser of the text terminal grid.
`default_nettype none
module ttg_parser import ttg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [CODE_W-1:0] data_byte,
  input  wire view_t             view,
  output parse_t                 parse
);

  logic             active_r, active_nxt;
  logic             second_r, second_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [ACC_W-1:0] col_acc_r, col_acc_nxt;
  logic [ACC_W-1:0] row_acc_r, row_acc_nxt;

  logic             is_print;
  logic             is_digit;
  logic [CNT_W-1:0] count_inc;
  logic [3:0]       digit;

  // Decimal accumulate, saturating at the largest byte value.
  function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [11:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, d};
    acc_digit = (v > 12'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
  endfunction

  assign is_print  = (data_byte >= CH_SPACE) && (data_byte <= CH_TILDE);
  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit     = 4'(data_byte - CH_ZERO);
  assign count_inc = count_r + 1'b1;

  always_comb begin
    parse.draw    = !active_r && (is_print || (data_byte == CH_NL));
    parse.set_cur = active_r && (data_byte == CH_H);
    parse.col     = (col_acc_r > ACC_W'(view.last_col)) ? view.last_col
                                                        : COL_W'(col_acc_r);
    parse.row     = (row_acc_r > ACC_W'(view.last_row)) ? view.last_row
                                                        : ROW_W'(row_acc_r);
  end

  always_comb begin
    active_nxt  = active_r;
    second_nxt  = second_r;
    count_nxt   = count_r;
    col_acc_nxt = col_acc_r;
    row_acc_nxt = row_acc_r;
    if (step) begin
      if (active_r) begin
        if (data_byte == CH_H) begin
          active_nxt = 1'b0;
        end else begin
          if (data_byte == CH_SEMI) begin
            second_nxt = 1'b1;
          end else if (is_digit) begin
            if (second_r) begin
              row_acc_nxt = acc_digit(row_acc_r, digit);
            end else begin
              col_acc_nxt = acc_digit(col_acc_r, digit);
            end
          end
          count_nxt = count_inc;
          // A sequence that runs too long is dropped with this byte.
          if (count_inc == CNT_W'(ESCAPE_LIMIT - 1)) begin
            active_nxt = 1'b0;
          end
        end
      end else if (data_byte == CH_ESC) begin
        active_nxt  = 1'b1;
        second_nxt  = 1'b0;
        count_nxt   = '0;
        col_acc_nxt = '0;
        row_acc_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      second_r  <= 1'b0;
      count_r   <= '0;
      col_acc_r <= '0;
      row_acc_r <= '0;
    end else begin
      active_r  <= active_nxt;
      second_r  <= second_nxt;
      count_r   <= count_nxt;
      col_acc_r <= col_acc_nxt;
      row_acc_r <= row_acc_nxt;
    end
  end

endmodule
`default_nettype wire

### design/ttg_ctrl.sv
// Grid sequencer: cursor, cell writes and reads, scroll copy, and result register.
`default_nettype none
module ttg_ctrl import ttg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_command,
  input  wire logic [CODE_W-1:0]     in_data_byte,
  input  wire logic [CELL_COL_W-1:0] in_read_col,
  input  wire logic [CELL_ROW_W-1:0] in_read_row,
  input  wire parse_t                parse,
  input  wire view_t                 view,
  output ram_req_t                   ram_req,
  input  wire logic [CODE_W-1:0]     ram_rdata,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_kind,
  output logic [CELL_COL_W-1:0]      out_cell_col,
  output logic [CELL_ROW_W-1:0]      out_cell_row,
  output logic [PIX_W-1:0]           out_pixel_x,
  output logic [PIX_W-1:0]           out_pixel_y,
  output logic [CODE_W-1:0]          out_char_code,
  output logic                       out_scrolled
);

  ctrl_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]    idx_r;
  logic [ADDR_W-1:0]    wr_addr_r;
  logic                 pend_r;
  logic [COL_W-1:0]     cur_col_r;
  logic [ROW_W-1:0]     cur_row_r;
  logic                 res_kind_r;
  logic [RES_COL_W-1:0] res_col_r;
  logic [RES_ROW_W-1:0] res_row_r;
  logic [CODE_W-1:0]    res_char_r;
  logic                 res_scroll_r;
  logic                 res_post_r;
  logic                 rd_oor_r;

  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [CELL_COL_W-1:0] out_col_r;
  logic [CELL_ROW_W-1:0] out_row_r;
  logic [PIX_W-1:0]     out_px_r;
  logic [PIX_W-1:0]     out_py_r;
  logic [CODE_W-1:0]    out_char_r;
  logic                 out_scroll_r;

  logic                 accept;
  logic                 out_free;
  logic [COL_W-1:0]     cl_col;
  logic [ROW_W-1:0]     cl_row;
  logic                 wrap;
  logic                 scroll;
  logic [ADDR_W-1:0]    copy_end;
  logic [ADDR_W-1:0]    wipe_last;
  logic [ADDR_W-1:0]    res_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 rd_in_range;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Cursor clamped into the box, and where it goes after a draw.
  assign cl_col = (cur_col_r > view.last_col) ? view.last_col : cur_col_r;
  assign cl_row = (cur_row_r > view.last_row) ? view.last_row : cur_row_r;
  assign wrap   = (cl_col == view.last_col) || (in_data_byte == CH_NL);
  assign scroll = wrap && (cl_row == view.last_row);

  assign copy_end  = ADDR_W'(32'(view.last_row) * MAX_COLUMNS);
  assign wipe_last = copy_end + ADDR_W'(MAX_COLUMNS - 1);
  assign res_addr  = ADDR_W'(32'(res_row_r) * MAX_COLUMNS + 32'(res_col_r));
  assign rd_addr   = ADDR_W'(32'(in_read_row) * MAX_COLUMNS + 32'(in_read_col));
  assign rd_in_range = (32'(in_read_col) < MAX_COLUMNS) && (32'(in_read_row) < MAX_ROWS);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (idx_r == ADDR_W'(GRID_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_READ) begin
            state_nxt = ST_READ;
          end else if (parse.draw) begin
            state_nxt = ST_DRAW;
          end
        end
      end
      ST_READ: state_nxt = ST_POST;
      ST_DRAW: begin
        if (res_scroll_r) begin
          state_nxt = ST_SCROLL;
        end else if (res_post_r) begin
          state_nxt = ST_POST;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        if ((idx_r == copy_end) && !pend_r) begin
          state_nxt = ST_WIPE;
        end
      end
      ST_WIPE: begin
        if (idx_r == wipe_last) begin
          state_nxt = res_post_r ? ST_POST : ST_IDLE;
        end
      end
      ST_POST: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    ram_req = '0;
    unique case (state_r)
      ST_CLEAR, ST_WIPE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        ram_req.wdata = '0;
      end
      ST_IDLE: begin
        ram_req.re    = accept && (in_command == CMD_READ);
        ram_req.raddr = rd_addr;
      end
      ST_DRAW: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = res_addr;
        ram_req.wdata = res_char_r;
      end
      ST_SCROLL: begin
        // Row r+1 is read in the cycle before its write into row r.
        ram_req.re    = (idx_r != copy_end);
        ram_req.raddr = idx_r + ADDR_W'(MAX_COLUMNS);
        ram_req.we    = pend_r;
        ram_req.waddr = wr_addr_r;
        ram_req.wdata = ram_rdata;
      end
      default: ram_req = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_CLEAR: idx_r <= idx_r + 1'b1;
        ST_IDLE: begin
          if (accept && (in_command == CMD_FEED)) begin
            if (parse.draw) begin
              cur_col_r <= wrap ? '0 : cl_col + 1'b1;
              cur_row_r <= (wrap && !scroll) ? cl_row + 1'b1 : cl_row;
            end else if (parse.set_cur) begin
              cur_col_r <= parse.col;
              cur_row_r <= parse.row;
            end
          end
        end
        ST_DRAW: begin
          idx_r  <= '0;
          pend_r <= 1'b0;
        end
        ST_SCROLL: begin
          if (idx_r != copy_end) begin
            idx_r  <= idx_r + 1'b1;
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
        end
        ST_WIPE: idx_r <= idx_r + 1'b1;
        default: ;
      endcase
      if ((state_r == ST_POST) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && accept) begin
      res_char_r <= in_data_byte;
      if (in_command == CMD_READ) begin
        res_kind_r   <= KIND_READ;
        res_col_r    <= RES_COL_W'(in_read_col);
        res_row_r    <= RES_ROW_W'(in_read_row);
        res_scroll_r <= 1'b0;
        res_post_r   <= 1'b1;
        rd_oor_r     <= !rd_in_range;
      end else begin
        res_kind_r   <= KIND_DRAW;
        res_col_r    <= RES_COL_W'(cl_col);
        res_row_r    <= RES_ROW_W'(cl_row);
        res_scroll_r <= scroll;
        res_post_r   <= view.visible;
        rd_oor_r     <= 1'b0;
      end
    end
    if (state_r == ST_READ) begin
      res_char_r <= rd_oor_r ? '0 : ram_rdata;
    end
    if (state_r == ST_SCROLL) begin
      wr_addr_r <= idx_r;
    end
    if ((state_r == ST_POST) && out_free) begin
      out_kind_r   <= res_kind_r;
      out_col_r    <= CELL_COL_W'(res_col_r);
      out_row_r    <= CELL_ROW_W'(res_row_r);
      out_px_r     <= PIX_W'(32'(res_col_r) * CELL_W + 32'(view.origin_x));
      out_py_r     <= PIX_W'(32'(res_row_r) * CELL_H + 32'(view.origin_y));
      out_char_r   <= res_char_r;
      out_scroll_r <= res_scroll_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_cell_col  = out_col_r;
  assign out_cell_row  = out_row_r;
  assign out_pixel_x   = out_px_r;
  assign out_pixel_y   = out_py_r;
  assign out_char_code = out_char_r;
  assign out_scrolled  = out_scroll_r;

endmodule
`default_nettype wire

### design/text_terminal_grid.sv
// Top level of the text terminal grid: configuration registers, parser, sequencer, grid RAM.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   command, data_byte, read_col, read_row
//   out_     output     out_valid / out_ready kind, cell_col, cell_row, pixel_x, pixel_y,
//                                             char_code, scrolled
//   cfg_     input      cfg_valid / cfg_ready index, data
//
// One item is worked at a time: a byte that draws nothing ends on acceptance, a draw writes
// its cell in the draw state, and a read or echoed draw loads its result in the post state.
// A scroll copies each row up by one row, moving one cell per cycle, then wipes the last row.
// After reset the grid RAM is zeroed, and no item is accepted until that is done.
// While the output register is full, the next item with a result waits in its last cycle
// and input stalls until the register frees.
`default_nettype none
module text_terminal_grid import ttg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_command,
  input  wire logic [CODE_W-1:0]     in_data_byte,
  input  wire logic [CELL_COL_W-1:0] in_read_col,
  input  wire logic [CELL_ROW_W-1:0] in_read_row,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_kind,
  output logic [CELL_COL_W-1:0]      out_cell_col,
  output logic [CELL_ROW_W-1:0]      out_cell_row,
  output logic [PIX_W-1:0]           out_pixel_x,
  output logic [PIX_W-1:0]           out_pixel_y,
  output logic [CODE_W-1:0]          out_char_code,
  output logic                       out_scrolled,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [COLS_REG_W-1:0] columns_r;
  logic [ROWS_REG_W-1:0] rows_r;
  logic [ORIGIN_W-1:0]   origin_x_r;
  logic [ORIGIN_W-1:0]   origin_y_r;
  logic                  visible_r;

  view_t             view;
  parse_t            parse;
  ram_req_t          ram_req;
  logic [CODE_W-1:0] ram_rdata;
  logic              step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r  <= COLS_REG_W'(40);
      rows_r     <= ROWS_REG_W'(30);
      origin_x_r <= '0;
      origin_y_r <= '0;
      visible_r  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COLUMNS:  columns_r  <= cfg_data[COLS_REG_W-1:0];
        REG_ROWS:     rows_r     <= cfg_data[ROWS_REG_W-1:0];
        REG_ORIGIN_X: origin_x_r <= cfg_data[ORIGIN_W-1:0];
        REG_ORIGIN_Y: origin_y_r <= cfg_data[ORIGIN_W-1:0];
        REG_VISIBLE:  visible_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Zero counts as one; anything above the grid size counts as the grid size.
  always_comb begin
    if (columns_r == '0) begin
      view.last_col = '0;
    end else if (32'(columns_r) > MAX_COLUMNS) begin
      view.last_col = COL_W'(MAX_COLUMNS - 1);
    end else begin
      view.last_col = COL_W'(columns_r - 1'b1);
    end
    if (rows_r == '0) begin
      view.last_row = '0;
    end else if (32'(rows_r) > MAX_ROWS) begin
      view.last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      view.last_row = ROW_W'(rows_r - 1'b1);
    end
    view.origin_x = origin_x_r;
    view.origin_y = origin_y_r;
    view.visible  = visible_r;
  end

  assign step = in_valid && in_ready && (in_command == CMD_FEED);

  ttg_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_byte),
    .view      (view),
    .parse     (parse)
  );

  ttg_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_data_byte  (in_data_byte),
    .in_read_col   (in_read_col),
    .in_read_row   (in_read_row),
    .parse         (parse),
    .view          (view),
    .ram_req       (ram_req),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_cell_col  (out_cell_col),
    .out_cell_row  (out_cell_row),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_char_code (out_char_code),
    .out_scrolled  (out_scrolled)
  );

  ttg_ram #(
    .WIDTH (CODE_W),
    .DEPTH (GRID_DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire
